[hw/rtl/lz78_phrase_encoder_top_defines.svh]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder assertion macros
// Concurrent assertion helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LZ78_PHRASE_ENCODER_TOP_DEFINES_SVH
`define LZ78_PHRASE_ENCODER_TOP_DEFINES_SVH

// prop must hold at every clock edge outside reset
`define LZPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond must never be seen outside reset
`define LZPE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/lz78pe_pkg.sv]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder package
// Sizes, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lz78pe_pkg;

  localparam int DICT_DEPTH = 1024;
  localparam int ADDR_W     = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int PHR_W      = $clog2(DICT_DEPTH + 1);
  localparam int SYM_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int OUT_IDX_W  = 11;
  localparam int ENTRY_W    = PHR_W + SYM_W;

  typedef struct packed {
    logic start;
    logic scan;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic last;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/lz78pe_ctrl.sv]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder controller
// Sequences accept, dictionary scan and token hand-off.
// ----------------------------------------------------------------------------
module lz78pe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lz78pe_pkg::status_t status_i,
  output lz78pe_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit && !status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.hit || status_i.miss) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/lz78pe_dpath.sv]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder datapath
// Dictionary memory, scan pointer, phrase state and output register.
// ----------------------------------------------------------------------------
module lz78pe_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lz78pe_pkg::cmd_t                    cmd_i,
  output lz78pe_pkg::status_t                 status_o,
  input  logic [lz78pe_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                                stream_end_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [lz78pe_pkg::OUT_IDX_W-1:0]    phrase_index_o,
  output logic [lz78pe_pkg::SYM_W-1:0]        next_symbol_o,
  output logic                                final_token_o
);

  logic [lz78pe_pkg::ENTRY_W-1:0]   mem [lz78pe_pkg::DICT_DEPTH];
  logic [lz78pe_pkg::ENTRY_W-1:0]   rd_data_q;
  logic [lz78pe_pkg::BYTE_W-1:0]    byte_q;
  logic                             last_q;
  logic [lz78pe_pkg::PHR_W-1:0]     phrase_q, count_q, scan_q, cmp_idx_q;
  logic                             cmp_vld_q;
  logic [lz78pe_pkg::OUT_IDX_W-1:0] tok_phrase_q;
  logic [lz78pe_pkg::SYM_W-1:0]     tok_sym_q;
  logic                             tok_final_q;
  logic                             out_valid_q;
  logic [lz78pe_pkg::OUT_IDX_W-1:0] out_phrase_q;
  logic [lz78pe_pkg::SYM_W-1:0]     out_sym_q;
  logic                             out_final_q;

  logic [lz78pe_pkg::SYM_W-1:0]     sym;
  logic [lz78pe_pkg::PHR_W-1:0]     hit_phrase;
  logic [lz78pe_pkg::ADDR_W-1:0]    rd_addr, wr_addr;
  logic                             issue, hit, miss, room, wr_en;

  always_comb begin
    sym        = {1'b0, byte_q} + lz78pe_pkg::SYM_W'(1);
    issue      = scan_q < count_q;
    rd_addr    = scan_q[lz78pe_pkg::ADDR_W-1:0];
    wr_addr    = count_q[lz78pe_pkg::ADDR_W-1:0];
    hit        = cmd_i.scan && cmp_vld_q && (rd_data_q == {phrase_q, sym});
    miss       = cmd_i.scan && !issue && !cmp_vld_q;
    room       = count_q < lz78pe_pkg::PHR_W'(lz78pe_pkg::DICT_DEPTH);
    wr_en      = miss && room;
    hit_phrase = cmp_idx_q + lz78pe_pkg::PHR_W'(1);
  end

  assign status_o.hit      = hit;
  assign status_o.miss     = miss;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {phrase_q, sym};
    end
    if (cmd_i.scan && issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      byte_q <= data_byte_i;
      last_q <= stream_end_i;
    end
    if (cmd_i.scan && issue) begin
      cmp_idx_q <= scan_q;
    end
    if (hit) begin
      tok_phrase_q <= lz78pe_pkg::OUT_IDX_W'(hit_phrase);
      tok_sym_q    <= '0;
      tok_final_q  <= 1'b1;
    end else if (miss) begin
      tok_phrase_q <= lz78pe_pkg::OUT_IDX_W'(phrase_q);
      tok_sym_q    <= sym;
      tok_final_q  <= last_q;
    end
    if (cmd_i.push) begin
      out_phrase_q <= tok_phrase_q;
      out_sym_q    <= tok_sym_q;
      out_final_q  <= tok_final_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      phrase_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= issue;
        if (issue) begin
          scan_q <= scan_q + lz78pe_pkg::PHR_W'(1);
        end
      end
      if (hit) begin
        if (last_q) begin
          phrase_q <= '0;
          count_q  <= '0;
        end else begin
          phrase_q <= hit_phrase;
        end
      end else if (miss) begin
        phrase_q <= '0;
        if (last_q) begin
          count_q <= '0;
        end else if (room) begin
          count_q <= count_q + lz78pe_pkg::PHR_W'(1);
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phrase_index_o = out_phrase_q;
  assign next_symbol_o  = out_sym_q;
  assign final_token_o  = out_final_q;

endmodule

[hw/rtl/lz78_phrase_encoder_top.sv]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder top level
// Byte-in, token-out LZ78 encoder with a 1024-entry on-chip dictionary.
// ----------------------------------------------------------------------------
// One byte is taken per transfer, then in_stall_o stays high while the
// dictionary is scanned for the current phrase extended by that byte. The
// dictionary sits in a single-port-read memory with registered read data, so
// the scan reads one stored entry per cycle. The dictionary holds at most
// 1024 entries, and a new token that finds the output register still full
// holds off the next byte. The scan stops at the first match. A miss
// produces one token, as does the last byte of a stream; the token waits in
// an output register, and a new byte is accepted while it is stalled there.
// The dictionary is tracked by a fill count, so no clearing pass is needed
// after reset or between streams.
module lz78_phrase_encoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lz78pe_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                                stream_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lz78pe_pkg::OUT_IDX_W-1:0]    phrase_index_o,
  output logic [lz78pe_pkg::SYM_W-1:0]        next_symbol_o,
  output logic                                final_token_o
);

  lz78pe_pkg::cmd_t    cmd;
  lz78pe_pkg::status_t status;

  lz78pe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lz78pe_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (data_byte_i),
    .stream_end_i   (stream_end_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .phrase_index_o (phrase_index_o),
    .next_symbol_o  (next_symbol_o),
    .final_token_o  (final_token_o)
  );

endmodule

[hw/rtl/lz78pe_checker.sv]
// ----------------------------------------------------------------------------
// LZ78 phrase encoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "lz78_phrase_encoder_top_defines.svh"

module lz78pe_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [lz78pe_pkg::OUT_IDX_W-1:0]    phrase_index_o,
  input logic [lz78pe_pkg::SYM_W-1:0]        next_symbol_o,
  input logic                                final_token_o
);

  `LZPE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(phrase_index_o) && $stable(next_symbol_o) && $stable(final_token_o), "stalled token changed")
  `LZPE_ASSERT(a_busy_after_in, in_valid_i && !in_stall_o |=> in_stall_o, "input taken while scanning")
  `LZPE_NEVER(a_flush_final, out_valid_o && (next_symbol_o == '0) && !final_token_o, "flush token not final")
  `LZPE_NEVER(a_sym_range, out_valid_o && next_symbol_o[lz78pe_pkg::SYM_W-1] && (next_symbol_o[lz78pe_pkg::SYM_W-2:0] != '0), "symbol out of range")

endmodule

bind lz78_phrase_encoder_top lz78pe_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .phrase_index_o (phrase_index_o),
  .next_symbol_o  (next_symbol_o),
  .final_token_o  (final_token_o)
);
